>>> rtl/core/b64d_pkg.sv
package b64d_pkg;

    // default depth of the group queue between front and back
    localparam int GROUP_FIFO_DEPTH = 4;

    // padding character
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // byte counts of one decoded group
    localparam logic [1:0] NBYTES_ONE   = 2'd1;
    localparam logic [1:0] NBYTES_TWO   = 2'd2;
    localparam logic [1:0] NBYTES_THREE = 2'd3;

    // one decoded group, queued for byte output
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  nbytes;
        logic        done;
    } t_group;

    // character to sextet, standard and url-safe alphabets plus ',' and '.'
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] s;
        s = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = 6'(c - 8'd71);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = 6'(c + 8'd4);
        end else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) begin
            s = 6'd62;
        end else if (c == 8'h2F || c == 8'h2C || c == 8'h5F) begin
            s = 6'd63;
        end
        return s;
    endfunction

endpackage

>>> rtl/core/b64d_if.sv
// character channel
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       message_end;

    modport source (output valid, output char_code, output message_end, input ready);
    modport sink   (input valid, input char_code, input message_end, output ready);
endinterface

// decoded byte channel
interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       run_last;
    logic       message_done;

    modport source (output valid, output data_byte, output run_last, output message_done,
                    input ready);
    modport sink   (input valid, input data_byte, input run_last, input message_done,
                    output ready);
endinterface

>>> rtl/core/b64d_front.sv
module b64d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    b64d_char_if.sink         i_char,
    input  logic              i_full,
    output logic              o_push,
    output b64d_pkg::t_group  o_group
);
    import b64d_pkg::*;

    logic [17:0] r_acc, n_acc;
    logic [1:0]  r_pos, n_pos;
    logic        r_twp, n_twp;

    logic        accept;
    logic [5:0]  s;
    logic [23:0] acc24;
    logic [23:0] end_bits;
    logic [1:0]  end_nbytes;
    logic        is_pad;

    assign i_char.ready = !i_full;
    assign accept = i_char.valid && !i_full;
    assign s      = sextet_of(i_char.char_code);
    assign acc24  = {r_acc, s};
    assign is_pad = (i_char.char_code == PAD_CHAR);

    // left-align a short final group
    always_comb begin
        unique case (r_pos)
            2'd0:    end_bits = {s, 18'd0};
            2'd1:    end_bits = {r_acc[5:0], s, 12'd0};
            2'd2:    end_bits = {r_acc[11:0], s, 6'd0};
            default: end_bits = acc24;
        endcase
    end

    // bytes emitted by the final group
    always_comb begin
        unique case (r_pos)
            2'd3:    end_nbytes = is_pad ? (r_twp ? NBYTES_ONE : NBYTES_TWO) : NBYTES_THREE;
            2'd2:    end_nbytes = is_pad ? NBYTES_ONE : NBYTES_TWO;
            default: end_nbytes = NBYTES_ONE;
        endcase
    end

    // group record toward the queue
    always_comb begin
        o_push = accept && (i_char.message_end || r_pos == 2'd3);
        if (i_char.message_end) begin
            o_group.bits   = end_bits;
            o_group.nbytes = end_nbytes;
            o_group.done   = 1'b1;
        end else begin
            o_group.bits   = acc24;
            o_group.nbytes = NBYTES_THREE;
            o_group.done   = 1'b0;
        end
    end

    // accumulator update
    always_comb begin
        n_acc = r_acc;
        n_pos = r_pos;
        n_twp = r_twp;
        if (accept) begin
            if (i_char.message_end || r_pos == 2'd3) begin
                n_acc = 18'd0;
                n_pos = 2'd0;
                n_twp = 1'b0;
            end else begin
                n_acc = acc24[17:0];
                n_pos = r_pos + 2'd1;
                if (r_pos == 2'd2) begin
                    n_twp = is_pad;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 18'd0;
            r_pos <= 2'd0;
            r_twp <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_pos <= n_pos;
            r_twp <= n_twp;
        end
    end

endmodule

>>> rtl/core/b64d_fifo.sv
module b64d_fifo #(
    parameter int P_DEPTH = b64d_pkg::GROUP_FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64d_pkg::t_group  i_data,
    input  logic              i_pop,
    output b64d_pkg::t_group  o_head,
    output logic              o_full,
    output logic              o_empty
);
    import b64d_pkg::*;

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(P_DEPTH);

    t_group           r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // pointer and fill count
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // queue never overflows or underflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("group queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("group queue underflow");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("group queue count out of range");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("group queue count did not advance on push");

endmodule

>>> rtl/core/b64d_back.sv
module b64d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64d_pkg::t_group  i_head,
    input  logic              i_empty,
    output logic              o_pop,
    b64d_byte_if.source       o_byte
);
    import b64d_pkg::*;

    logic       r_valid, n_valid;
    logic [1:0] r_idx, n_idx;
    logic [7:0] r_data;
    logic       r_last;
    logic       r_done;

    logic       out_free;
    logic       emit;
    logic       last;
    logic [7:0] sel_byte;

    assign out_free = !r_valid || o_byte.ready;
    assign emit     = out_free && !i_empty;
    assign last     = (r_idx == i_head.nbytes - 2'd1);
    assign o_pop    = emit && last;

    // byte of the head group, most significant first
    always_comb begin
        unique case (r_idx)
            2'd0:    sel_byte = i_head.bits[23:16];
            2'd1:    sel_byte = i_head.bits[15:8];
            default: sel_byte = i_head.bits[7:0];
        endcase
    end

    // byte index and output valid
    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (emit) begin
            n_valid = 1'b1;
            n_idx   = last ? 2'd0 : r_idx + 2'd1;
        end else if (o_byte.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_data <= sel_byte;
            r_last <= last;
            r_done <= last && i_head.done;
        end
    end

    assign o_byte.valid        = r_valid;
    assign o_byte.data_byte    = r_data;
    assign o_byte.run_last     = r_last;
    assign o_byte.message_done = r_done;

endmodule

>>> rtl/core/base64_stream_decoder.sv
// Streaming base64 decoder. One character transaction is taken per clock on i_char while the
// group queue has a free entry, with message_end set on the last character of a message;
// decoded bytes leave on o_byte, one per clock at most, with run_last on the last byte a
// character caused and message_done on the final byte of a message. The front stage
// classifies each character and packs groups of four sextets; each finished group (three
// bytes, or one to three for a final group) is written to a P_DEPTH-entry group queue, and
// the back stage drains the queue one byte per cycle, while the sink is ready, into a
// registered output. Input is ready whenever the group queue has a free entry, so the input
// side runs at one character per cycle as long as the byte sink keeps up with the byte
// stream; a byte reaches o_byte through the group queue and then the output register. Both
// alphabets plus ',' and '.' decode; any other byte decodes as zero.
module base64_stream_decoder #(
    parameter int P_DEPTH = b64d_pkg::GROUP_FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    b64d_char_if.sink    i_char,
    b64d_byte_if.source  o_byte
);
    import b64d_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_group push_group;
    t_group head_group;

    // character classification and group packing
    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_full  (full),
        .o_push  (push),
        .o_group (push_group)
    );

    // group queue
    b64d_fifo #(
        .P_DEPTH (P_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_group),
        .i_pop   (pop),
        .o_head  (head_group),
        .o_full  (full),
        .o_empty (empty)
    );

    // byte output
    b64d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_group),
        .i_empty (empty),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule

>>> tb/sv/base64_stream_decoder_tb.sv
`timescale 1ns / 1ps

module base64_stream_decoder_tb;
    import b64d_pkg::*;

    // one decoded byte as it should leave the block
    typedef struct {
        logic [7:0] data_byte;
        logic       run_last;
        logic       message_done;
    } t_byte_exp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    b64d_char_if char_bus ();
    b64d_byte_if byte_bus ();

    base64_stream_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_byte  (byte_bus)
    );

    // decoder state mirror
    logic [17:0] sextet_acc;
    logic [1:0]  group_pos;
    logic        third_pad;

    t_byte_exp   pending_bytes[$];

    int  fail_count    = 0;
    int  chars_sent    = 0;
    int  msgs_sent     = 0;
    int  bytes_checked = 0;
    bit  send_idle     = 1'b1;
    bit  sink_idle     = 1'b1;
    bit  hold_req      = 1'b0;
    int  hold_left     = 0;
    int  stall_left    = 0;

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // character to sextet, both alphabets plus ',' and '.'
    function automatic logic [5:0] char_sextet(input logic [7:0] c);
        logic [5:0] s;
        s = 6'd0;
        if (c >= "A" && c <= "Z") begin
            s = 6'(c - 8'd65);
        end else if (c >= "a" && c <= "z") begin
            s = 6'(c - 8'd97 + 8'd26);
        end else if (c >= "0" && c <= "9") begin
            s = 6'(c - 8'd48 + 8'd52);
        end else if (c == "+" || c == "-" || c == ".") begin
            s = 6'd62;
        end else if (c == "/" || c == "_" || c == ",") begin
            s = 6'd63;
        end
        return s;
    endfunction

    // sextet to a character, picking among the alternate spellings of 62 and 63
    function automatic logic [7:0] alphabet_char(input int s);
        logic [7:0] c;
        int         pick;
        pick = $urandom_range(0, 2);
        if (s < 26) begin
            c = 8'(65 + s);
        end else if (s < 52) begin
            c = 8'(97 + s - 26);
        end else if (s < 62) begin
            c = 8'(48 + s - 52);
        end else if (s == 62) begin
            c = (pick == 0) ? "+" : (pick == 1) ? "-" : ".";
        end else begin
            c = (pick == 0) ? "/" : (pick == 1) ? "_" : ",";
        end
        return c;
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic last, input logic done);
        t_byte_exp e;
        e.data_byte    = b;
        e.run_last     = last;
        e.message_done = done;
        pending_bytes.insert(pending_bytes.size(), e);
    endfunction

    // expected bytes for one accepted character
    function automatic void decode_char(input logic [7:0] c, input logic fin);
        logic [23:0] acc24;
        logic [23:0] grp;
        int          cnt;
        bit          second;
        acc24 = {sextet_acc, char_sextet(c)};
        cnt   = int'(group_pos) + 1;
        if (!fin) begin
            if (group_pos == 2'd3) begin
                queue_byte(acc24[23:16], 1'b0, 1'b0);
                queue_byte(acc24[15:8], 1'b0, 1'b0);
                queue_byte(acc24[7:0], 1'b1, 1'b0);
                sextet_acc = '0;
                group_pos  = '0;
                third_pad  = 1'b0;
            end else begin
                if (group_pos == 2'd2)
                    third_pad = (c == PAD_CHAR);
                sextet_acc = acc24[17:0];
                group_pos  = group_pos + 2'd1;
            end
            return;
        end
        // final group: left-align what arrived, then decide how many bytes it holds
        grp = acc24 << (6 * (4 - cnt));
        if (cnt == 4 && c != PAD_CHAR) begin
            queue_byte(grp[23:16], 1'b0, 1'b0);
            queue_byte(grp[15:8], 1'b0, 1'b0);
            queue_byte(grp[7:0], 1'b1, 1'b1);
        end else begin
            if (cnt == 4)
                second = !third_pad;
            else if (cnt == 3)
                second = (c != PAD_CHAR);
            else
                second = 1'b0;
            if (second) begin
                queue_byte(grp[23:16], 1'b0, 1'b0);
                queue_byte(grp[15:8], 1'b1, 1'b1);
            end else begin
                queue_byte(grp[23:16], 1'b1, 1'b1);
            end
        end
        sextet_acc = '0;
        group_pos  = '0;
        third_pad  = 1'b0;
    endfunction

    // offer one character, optionally after an idle burst, and predict on the transaction
    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        if (send_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_bus.valid       <= 1'b1;
        char_bus.char_code   <= c;
        char_bus.message_end <= fin;
        do @(posedge i_clk); while (!char_bus.ready);
        decode_char(c, fin);
        chars_sent++;
        if (fin)
            msgs_sent++;
    endtask

    task automatic send_message(input logic [7:0] msg[$]);
        foreach (msg[k])
            send_char(msg[k], k == msg.size() - 1);
    endtask

    // byte sink: random stall bursts, plus a long hold-off on request
    initial begin
        byte_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = 80;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                byte_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                byte_bus.ready <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                byte_bus.ready <= 1'b0;
            end else begin
                byte_bus.ready <= 1'b1;
            end
        end
    end

    // compare each byte transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_byte_exp e;
        if (i_rst_n && byte_bus.valid && byte_bus.ready) begin
            if (pending_bytes.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected byte %02h last %0b done %0b at %0t",
                             byte_bus.data_byte, byte_bus.run_last, byte_bus.message_done,
                             $realtime);
                fail_count++;
            end else begin
                e = pending_bytes.pop_front();
                bytes_checked++;
                if (byte_bus.data_byte !== e.data_byte || byte_bus.run_last !== e.run_last
                        || byte_bus.message_done !== e.message_done) begin
                    if (fail_count < 10)
                        $display("mismatch at %0t: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                 $realtime, e.data_byte, e.run_last, e.message_done,
                                 byte_bus.data_byte, byte_bus.run_last, byte_bus.message_done);
                    fail_count++;
                end
            end
        end
    end

    // edges of the alphabets, unknown bytes, final groups of one, three and four characters, padding mid-message
    task automatic test_directed();
        // full final group with '=' in third place still gives three bytes
        send_message('{"A", "Z", PAD_CHAR, "z"});
        send_message('{"/", "-", "_"});
        send_message('{",", ".", 8'hFF, 8'h00});
        send_message('{8'h80});
        send_message('{"+", "U", PAD_CHAR});
        send_message('{"Q", "U", PAD_CHAR, PAD_CHAR});
        send_message('{"a", "0", "9", PAD_CHAR});
    endtask

    // mostly well-formed messages with random content, some noise and misplaced padding
    task automatic test_random_messages(input int n_items);
        logic [7:0] msg[$];
        int         sent;
        int         kind;
        int         len;
        sent = 0;
        while (sent < n_items) begin
            msg.delete();
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 14);
            for (int k = 0; k < len; k++) begin
                if (kind < 7)
                    msg.insert(msg.size(), alphabet_char($urandom_range(0, 63)));
                else
                    msg.insert(msg.size(), 8'($urandom_range(0, 255)));
            end
            if (kind < 7 && $urandom_range(0, 1) == 1) begin
                while (msg.size() % 4 != 0)
                    msg.insert(msg.size(), PAD_CHAR);
            end else if (kind == 9) begin
                msg[$urandom_range(0, msg.size() - 1)] = PAD_CHAR;
            end
            send_message(msg);
            sent += msg.size();
        end
    endtask

    // sink holds off for a long stretch while characters keep coming
    task automatic test_backpressure(input int n_items);
        logic [7:0] msg[$];
        send_idle = 1'b0;
        hold_req  = 1'b1;
        for (int k = 0; k < n_items; k++)
            msg.insert(msg.size(), alphabet_char($urandom_range(0, 63)));
        send_message(msg);
        send_idle = 1'b1;
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_streaming(input int n_items);
        send_idle = 1'b0;
        sink_idle = 1'b0;
        test_random_messages(n_items);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (pending_bytes.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        sextet_acc = '0;
        group_pos  = '0;
        third_pad  = 1'b0;
        i_rst_n              <= 1'b0;
        char_bus.valid       <= 1'b0;
        char_bus.char_code   <= 8'h00;
        char_bus.message_end <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_messages(180);
        test_backpressure(32);
        test_streaming(50);

        char_bus.valid <= 1'b0;
        wait_drained();
        if (pending_bytes.size() != 0) begin
            $display("%0d expected bytes never arrived", pending_bytes.size());
            fail_count++;
        end

        $display("sent %0d characters in %0d messages, checked %0d decoded bytes",
                 chars_sent, msgs_sent, bytes_checked);
        $display("covered alphabet edges, padding shapes, noise, sink hold-off, streaming");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d bytes outstanding", pending_bytes.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
